@@ sv/svpp_pkg.sv @@
// Shared types and constants for the spherical view perspective projector.
package svpp_pkg;

  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 23;

  localparam logic [CfgIdxW-1:0] REG_SIN_THETA = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_COS_THETA = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_SIN_PHI = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_COS_PHI = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_VIEW_RADIUS = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_VIEW_DISTANCE = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_CENTER_X = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_CENTER_Y = 3'd7;

  // Projection factor used in place of view_distance / depth at zero depth.
  localparam logic [16:0] ZERO_DEPTH_GAIN = 17'd100;

  localparam int QuotW = 16;
  localparam logic signed [15:0] PIX_MAX = 16'sh7FFF;
  localparam logic signed [15:0] PIX_MIN = 16'sh8000;

  typedef struct packed {
    logic signed [15:0] sin_theta;
    logic signed [15:0] cos_theta;
    logic signed [15:0] sin_phi;
    logic signed [15:0] cos_phi;
    logic [22:0] view_radius;
    logic [15:0] view_distance;
    logic signed [15:0] center_x;
    logic signed [15:0] center_y;
  } cfg_t;

  typedef struct packed {
    logic valid;
    logic tag;
    logic signed [15:0] pix;
    logic clip;
  } pix_t;

endpackage

@@ sv/svpp_xform.sv @@
// View rotation pipeline: world point to view-space x, y and depth.
module svpp_xform #(
  parameter int TrigFrac = 14,
  parameter int VW = 45
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  svpp_pkg::cfg_t cfg,
  input  logic in_valid,
  input  logic in_func,
  input  logic signed [23:0] in_x,
  input  logic signed [23:0] in_y,
  input  logic signed [23:0] in_z,
  output logic out_valid,
  output logic out_func,
  output logic signed [VW-1:0] out_vx,
  output logic signed [VW-1:0] out_vy,
  output logic signed [VW-1:0] out_vd
);

  logic v1, v2, v3, v4, v5;
  logic f1, f2, f3, f4, f5;
  logic signed [23:0] x1, y1, z1;
  logic signed [39:0] xct, yst, xst, yct, zsp2, zcp2;
  logic signed [40:0] u3, vx3;
  logic signed [39:0] zsp3, zcp3, zsp4, zcp4;
  logic signed [56:0] ucp4, usp4;
  logic signed [40:0] vx4;
  logic signed [VW-1:0] vx5, vy5, vd5;
  logic signed [VW-1:0] radius_term;

  assign radius_term = $signed(VW'({1'b0, cfg.view_radius})) <<< TrigFrac;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1 <= in_func;
      x1 <= in_x;
      y1 <= in_y;
      // The negation of z is folded into the signs of the z terms below.
      z1 <= in_z;

      f2 <= f1;
      xct <= x1 * cfg.cos_theta;
      yst <= y1 * cfg.sin_theta;
      xst <= x1 * cfg.sin_theta;
      yct <= y1 * cfg.cos_theta;
      zsp2 <= z1 * cfg.sin_phi;
      zcp2 <= z1 * cfg.cos_phi;

      f3 <= f2;
      u3 <= 41'(xct) + 41'(yst);
      vx3 <= 41'(yct) - 41'(xst);
      zsp3 <= zsp2;
      zcp3 <= zcp2;

      f4 <= f3;
      ucp4 <= u3 * cfg.cos_phi;
      usp4 <= u3 * cfg.sin_phi;
      vx4 <= vx3;
      zsp4 <= zsp3;
      zcp4 <= zcp3;

      f5 <= f4;
      vx5 <= VW'(vx4);
      vy5 <= -VW'(ucp4 >>> TrigFrac) - VW'(zsp4);
      vd5 <= -VW'(usp4 >>> TrigFrac) + VW'(zcp4) + radius_term;
    end
  end

  assign out_valid = v5;
  assign out_func = f5;
  assign out_vx = vx5;
  assign out_vy = vy5;
  assign out_vd = vd5;

endmodule

@@ sv/svpp_div.sv @@
// Projection of one coordinate: scale, add centre, divide by depth, saturate.
module svpp_div #(
  parameter int UnitShift = 22,
  parameter int VW = 45,
  parameter int NW = 63
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic [15:0] view_distance,
  input  logic signed [15:0] center,
  input  logic in_valid,
  input  logic in_tag,
  input  logic signed [VW-1:0] in_v,
  input  logic signed [VW-1:0] in_vd,
  output svpp_pkg::pix_t out
);

  localparam int QW = svpp_pkg::QuotW;

  logic p1_valid, p2_valid, p3_valid;
  logic p1_tag, p2_tag, p3_tag;
  logic signed [VW+16:0] p1_vm;
  logic signed [VW+15:0] p1_cd;
  logic signed [VW-1:0] p1_d, p2_d;
  logic signed [NW-1:0] p2_n;
  logic [NW-1:0] p3_nmag;
  logic [VW-1:0] p3_dmag;
  logic p3_neg;

  logic signed [VW-1:0] d_sel;
  logic signed [16:0] m_sel;

  logic [NW-1:0] rem [0:QW];
  logic [VW-1:0] dm [0:QW];
  logic [QW-1:0] qq [0:QW];
  logic ng [0:QW];
  logic ov [0:QW];
  logic vl [0:QW];
  logic tg [0:QW];

  logic [QW-1:0] q_fin;
  logic signed [15:0] pix_next;
  logic clip_next;

  // A zero depth divides by one fixed-point unit and uses ZERO_DEPTH_GAIN.
  always_comb begin
    if (in_vd == '0) begin
      d_sel = $signed(VW'(1)) <<< UnitShift;
      m_sel = $signed(svpp_pkg::ZERO_DEPTH_GAIN);
    end else begin
      d_sel = in_vd;
      m_sel = $signed({1'b0, view_distance});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
      p3_valid <= 1'b0;
      vl[0] <= 1'b0;
    end else if (en) begin
      p1_valid <= in_valid;
      p2_valid <= p1_valid;
      p3_valid <= p2_valid;
      vl[0] <= p3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_tag <= in_tag;
      p1_vm <= in_v * m_sel;
      p1_cd <= center * d_sel;
      p1_d <= d_sel;

      p2_tag <= p1_tag;
      p2_n <= NW'(p1_vm) + NW'(p1_cd);
      p2_d <= p1_d;

      p3_tag <= p2_tag;
      p3_nmag <= p2_n[NW-1] ? NW'(-p2_n) : NW'(p2_n);
      p3_dmag <= p2_d[VW-1] ? VW'(-p2_d) : VW'(p2_d);
      p3_neg <= p2_n[NW-1] ^ p2_d[VW-1];

      // A quotient of 2^16 or more saturates whatever its sign.
      tg[0] <= p3_tag;
      rem[0] <= p3_nmag;
      dm[0] <= p3_dmag;
      qq[0] <= '0;
      ng[0] <= p3_neg;
      ov[0] <= p3_nmag >= (NW'(p3_dmag) << QW);
    end
  end

  // One quotient bit per stage, most significant first.
  for (genvar i = 0; i < QW; i++) begin : g_step
    logic [NW-1:0] shifted;
    logic take;

    assign shifted = NW'(dm[i]) << (QW - 1 - i);
    assign take = rem[i] >= shifted;

    always_ff @(posedge clk) begin
      if (rst) begin
        vl[i+1] <= 1'b0;
      end else if (en) begin
        vl[i+1] <= vl[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1] <= take ? rem[i] - shifted : rem[i];
        qq[i+1] <= qq[i] | (take ? (QW'(1) << (QW - 1 - i)) : '0);
        dm[i+1] <= dm[i];
        ng[i+1] <= ng[i];
        ov[i+1] <= ov[i];
        tg[i+1] <= tg[i];
      end
    end
  end

  assign q_fin = qq[QW];

  always_comb begin
    clip_next = 1'b0;
    pix_next = $signed(q_fin);
    if (ov[QW]) begin
      clip_next = 1'b1;
      pix_next = ng[QW] ? svpp_pkg::PIX_MIN : svpp_pkg::PIX_MAX;
    end else if (ng[QW]) begin
      if (q_fin > 16'd32768) begin
        clip_next = 1'b1;
        pix_next = svpp_pkg::PIX_MIN;
      end else begin
        pix_next = $signed(-q_fin);
      end
    end else if (q_fin[15]) begin
      clip_next = 1'b1;
      pix_next = svpp_pkg::PIX_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out.valid <= 1'b0;
    end else if (en) begin
      out.valid <= vl[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out.tag <= tg[QW];
      out.pix <= pix_next;
      out.clip <= clip_next;
    end
  end

endmodule

@@ sv/spherical_view_perspective_projector_top.sv @@
// Top level of the spherical view perspective projector.
// Usage:
// The slave stream takes one world point per word: s_tdata holds world_x,
// world_y and world_z (signed fixed point), s_tuser holds the pen command.
// The master stream returns one word per point: screen_x and screen_y in
// m_tdata, pen_draw and clipped in m_tuser.
// The configuration channel writes view registers by index; it is always
// ready and should be used only while no point is in flight.
// One word is taken every cycle unless the receiver stalls; the rate is set
// by the single shared clock enable of the pipeline (5 rotation stages,
// 4 projection stages, 16 divider stages at one quotient bit each, and the
// output register).
// When the receiver stalls, the whole pipeline holds and s_tready drops;
// nothing is lost or repeated.
// Reset clears all valid bits and loads the default view registers.
module spherical_view_perspective_projector_top #(
  parameter int COORD_FRAC_BITS = 8,
  parameter int TRIG_FRAC_BITS = 14
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [71:0] s_tdata,   // world_x, world_y, world_z
  input  logic s_tuser,          // func
  output logic m_tvalid,
  input  logic m_tready,
  output logic [31:0] m_tdata,   // screen_x, screen_y
  output logic [1:0] m_tuser,    // pen_draw, clipped
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [svpp_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [svpp_pkg::CfgDataW-1:0] cfg_data
);

  localparam int FloorW = 57 - TRIG_FRAC_BITS;
  localparam int RadW = 24 + TRIG_FRAC_BITS;
  localparam int MaxW0 = (FloorW > 40) ? FloorW : 40;
  localparam int MaxW1 = (MaxW0 > RadW) ? MaxW0 : RadW;
  localparam int VW = MaxW1 + 2;
  localparam int NW = VW + 18;

  svpp_pkg::cfg_t cfg;
  svpp_pkg::pix_t px, py;
  logic en;
  logic xf_valid, xf_func;
  logic signed [VW-1:0] xf_vx, xf_vy, xf_vd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sin_theta <= 16'sd0;
      cfg.cos_theta <= 16'sd16384;
      cfg.sin_phi <= 16'sd0;
      cfg.cos_phi <= -16'sd16384;
      cfg.view_radius <= 23'd2560;
      cfg.view_distance <= 16'd500;
      cfg.center_x <= 16'sd0;
      cfg.center_y <= 16'sd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        svpp_pkg::REG_SIN_THETA: cfg.sin_theta <= $signed(cfg_data[15:0]);
        svpp_pkg::REG_COS_THETA: cfg.cos_theta <= $signed(cfg_data[15:0]);
        svpp_pkg::REG_SIN_PHI: cfg.sin_phi <= $signed(cfg_data[15:0]);
        svpp_pkg::REG_COS_PHI: cfg.cos_phi <= $signed(cfg_data[15:0]);
        svpp_pkg::REG_VIEW_RADIUS: cfg.view_radius <= cfg_data;
        svpp_pkg::REG_VIEW_DISTANCE: cfg.view_distance <= cfg_data[15:0];
        svpp_pkg::REG_CENTER_X: cfg.center_x <= $signed(cfg_data[15:0]);
        svpp_pkg::REG_CENTER_Y: cfg.center_y <= $signed(cfg_data[15:0]);
        default: ;
      endcase
    end
  end

  assign en = !m_tvalid || m_tready;
  assign s_tready = en;

  svpp_xform #(
    .TrigFrac(TRIG_FRAC_BITS),
    .VW(VW)
  ) u_xform (
    .clk(clk),
    .rst(rst),
    .en(en),
    .cfg(cfg),
    .in_valid(s_tvalid),
    .in_func(s_tuser),
    .in_x($signed(s_tdata[23:0])),
    .in_y($signed(s_tdata[47:24])),
    .in_z($signed(s_tdata[71:48])),
    .out_valid(xf_valid),
    .out_func(xf_func),
    .out_vx(xf_vx),
    .out_vy(xf_vy),
    .out_vd(xf_vd)
  );

  svpp_div #(
    .UnitShift(COORD_FRAC_BITS + TRIG_FRAC_BITS),
    .VW(VW),
    .NW(NW)
  ) u_div_x (
    .clk(clk),
    .rst(rst),
    .en(en),
    .view_distance(cfg.view_distance),
    .center(cfg.center_x),
    .in_valid(xf_valid),
    .in_tag(xf_func),
    .in_v(xf_vx),
    .in_vd(xf_vd),
    .out(px)
  );

  svpp_div #(
    .UnitShift(COORD_FRAC_BITS + TRIG_FRAC_BITS),
    .VW(VW),
    .NW(NW)
  ) u_div_y (
    .clk(clk),
    .rst(rst),
    .en(en),
    .view_distance(cfg.view_distance),
    .center(cfg.center_y),
    .in_valid(xf_valid),
    .in_tag(xf_func),
    .in_v(xf_vy),
    .in_vd(xf_vd),
    .out(py)
  );

  assign m_tvalid = px.valid && py.valid;
  assign m_tdata = {py.pix, px.pix};
  assign m_tuser = {px.clip || py.clip, px.tag && py.tag};

`ifndef SYNTHESIS
  a_lanes_aligned: assert property (@(posedge clk) disable iff (rst)
    px.valid == py.valid && (!px.valid || px.tag == py.tag))
    else $error("projection lanes out of step");

  a_clip_at_limit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |->
      $signed(m_tdata[15:0]) == svpp_pkg::PIX_MAX ||
      $signed(m_tdata[15:0]) == svpp_pkg::PIX_MIN ||
      $signed(m_tdata[31:16]) == svpp_pkg::PIX_MAX ||
      $signed(m_tdata[31:16]) == svpp_pkg::PIX_MIN)
    else $error("clipped flag without a saturated pixel");

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");
`endif

endmodule
